// ----- hw/rtl/ratu_pkg.sv -----
// shared types, widths and codes of the ack tracker
`default_nettype none

package ratu_pkg;

    // sizing
    localparam int TABLE_DEPTH = 16;
    localparam int ID_COUNT    = 1024;
    localparam int TIDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAP_AW      = $clog2(ID_COUNT);

    // field widths
    localparam int ACT_W  = 2;
    localparam int ID_W   = 10;
    localparam int HND_W  = 8;
    localparam int KIND_W = 3;
    localparam int PEND_W = 5;
    localparam int TIME_W = 32;
    localparam int TO_W   = 16;

    // request actions
    localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DATA = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SENT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RETX     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELIVER  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUP      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ACK_HIT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ACK_MISS = 3'd6;

    // compare unit operations
    localparam logic ALU_EQ  = 1'b0;
    localparam logic ALU_AGE = 1'b1;

    // one pending table entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HND_W-1:0]  payload;
        logic [HND_W-1:0]  peer;
        logic [HND_W-1:0]  flags;
        logic [TIME_W-1:0] sent;
    } t_entry;

    // one result
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [HND_W-1:0]  payload;
        logic [HND_W-1:0]  peer;
        logic [HND_W-1:0]  flags;
        logic [PEND_W-1:0] pending;
        logic [TIME_W-1:0] tx;
        logic              last;
    } t_result;

    // request to the shared compare unit
    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] c;
    } t_alu_req;

endpackage

`default_nettype wire

// ----- hw/rtl/reliable_message_ack_tracker_unit.sv -----
// top level of the ack tracker: request sequencer, counters and result register
//
// Requests come in on i_in_valid / o_in_stall with one port per field; results
// leave on o_out_valid / i_out_stall. A request is taken at an edge where valid
// is high and stall is low. The timeout register is written by i_cfg_wr_en with
// i_cfg_wr_data; the user must write it only while the block is idle, as the
// block does not enforce this.
// Incoming data reads the received-id bitmap, then writes it. An ack walks the
// pending table one entry per cycle through the shared compare unit and, on a
// hit, then compacts the table one entry per cycle. A tick walks the table the
// same way and gives one retransmit result per expired entry; each result of a
// tick is held back until the next one so that the last flag of the last one
// can be set. One request is in work at a time.
// After reset the received-id bitmap is cleared one id per cycle; no request is
// taken until it is clear. A stalled receiver holds the sequencer whenever it
// has a result to hand over; the result register keeps its value.
`default_nettype none

module reliable_message_ack_tracker_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ratu_pkg::TO_W-1:0]   i_cfg_wr_data,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [ratu_pkg::ACT_W-1:0]  i_action,
    input  wire logic [ratu_pkg::ID_W-1:0]   i_msg_id,
    input  wire logic [ratu_pkg::HND_W-1:0]  i_payload_handle,
    input  wire logic [ratu_pkg::HND_W-1:0]  i_peer_handle,
    input  wire logic [ratu_pkg::HND_W-1:0]  i_send_flags,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [ratu_pkg::KIND_W-1:0] o_kind,
    output logic      [ratu_pkg::ID_W-1:0]   o_out_id,
    output logic      [ratu_pkg::HND_W-1:0]  o_out_payload,
    output logic      [ratu_pkg::HND_W-1:0]  o_out_peer,
    output logic      [ratu_pkg::HND_W-1:0]  o_out_flags,
    output logic      [ratu_pkg::PEND_W-1:0] o_pending_now,
    output logic      [ratu_pkg::TIME_W-1:0] o_transmissions,
    output logic                             o_last
);
    import ratu_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_CLR       = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_SEND      = 4'd2;
    localparam logic [3:0] ST_ACK_SCAN  = 4'd3;
    localparam logic [3:0] ST_ACK_SHIFT = 4'd4;
    localparam logic [3:0] ST_DATA_RD   = 4'd5;
    localparam logic [3:0] ST_DATA_WR   = 4'd6;
    localparam logic [3:0] ST_TICK_SCAN = 4'd7;
    localparam logic [3:0] ST_TICK_END  = 4'd8;

    // control registers
    logic [3:0]        r_state,    n_state;
    logic [CNT_W-1:0]  r_idx,      n_idx;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [ID_W-1:0]   r_next_id,  n_next_id;
    logic [TIME_W-1:0] r_now,      n_now;
    logic [TIME_W-1:0] r_tx,       n_tx;
    logic [TO_W-1:0]   r_timeout;
    logic [MAP_AW-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_valid;
    logic              r_hold_v,   n_hold_v;

    // payload registers
    logic [ID_W-1:0]   r_id,  n_id;
    logic [HND_W-1:0]  r_pay, n_pay;
    logic [HND_W-1:0]  r_peer, n_peer;
    logic [HND_W-1:0]  r_flg, n_flg;
    t_result           r_out;
    t_result           r_hold, n_hold;

    // datapath wires
    logic              out_free;
    logic              out_load;
    t_result           out_res;
    logic              scan_live;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  rd_pos;
    logic [TIME_W-1:0] tx_inc;
    logic [ID_W:0]     id_inc;
    logic              id_in_range;
    t_entry            rd_entry;
    logic              tbl_we;
    logic [TIDX_W-1:0] tbl_widx;
    t_entry            tbl_wentry;
    t_alu_req          alu_req;
    logic              alu_hit;
    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr;
    logic [0:0]        ram_wdata;
    logic [0:0]        ram_rdata;

    // pending table, shared compare unit and received-id bitmap
    ratu_table u_table (
        .i_clk      (i_clk),
        .i_rd_idx   (rd_pos[TIDX_W-1:0]),
        .o_rd_entry (rd_entry),
        .i_wr_en    (tbl_we),
        .i_wr_idx   (tbl_widx),
        .i_wr_entry (tbl_wentry)
    );

    ratu_alu u_alu (
        .i_req (alu_req),
        .o_hit (alu_hit)
    );

    ratu_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_rx_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_id[MAP_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // handshake and helper values
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign scan_live   = (r_idx < r_count);
    assign idx_inc     = r_idx + CNT_W'(1);
    assign tx_inc      = (r_tx == '1) ? r_tx : r_tx + TIME_W'(1);
    assign id_inc      = {1'b0, r_next_id} + (ID_W + 1)'(1);
    assign id_in_range = ({1'b0, r_id} < (ID_W + 1)'(ID_COUNT));

    // table read address is taken from the next sequencer index (one entry further on in compaction)
    assign rd_pos = (n_state == ST_ACK_SHIFT) ? n_idx + CNT_W'(1) : n_idx;

    // compare unit operands: age check in tick scans, id match otherwise
    always_comb begin
        alu_req.op = (r_state == ST_TICK_SCAN) ? ALU_AGE : ALU_EQ;
        alu_req.c  = TIME_W'(r_timeout);
        if (r_state == ST_TICK_SCAN) begin
            alu_req.a = r_now;
            alu_req.b = rd_entry.sent;
        end else begin
            alu_req.a = TIME_W'(rd_entry.id);
            alu_req.b = TIME_W'(r_id);
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_now      = r_now;
        n_tx       = r_tx;
        n_clr_addr = r_clr_addr;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_id       = r_id;
        n_pay      = r_pay;
        n_peer     = r_peer;
        n_flg      = r_flg;
        tbl_we     = 1'b0;
        tbl_widx   = r_idx[TIDX_W-1:0];
        tbl_wentry = rd_entry;
        ram_we     = 1'b0;
        ram_waddr  = r_clr_addr;
        ram_wdata  = 1'b0;
        out_load   = 1'b0;
        out_res    = '0;

        case (r_state)
            // clear the bitmap one id per cycle
            ST_CLR: begin
                ram_we = 1'b1;
                if (r_clr_addr == MAP_AW'(ID_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + MAP_AW'(1);
                end
            end

            // take a request
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_id   = i_msg_id;
                    n_pay  = i_payload_handle;
                    n_peer = i_peer_handle;
                    n_flg  = i_send_flags;
                    n_idx  = '0;
                    case (i_action)
                        ACT_SEND: n_state = ST_SEND;
                        ACT_ACK:  n_state = ST_ACK_SCAN;
                        ACT_DATA: n_state = ST_DATA_RD;
                        ACT_TICK: begin
                            n_now   = r_now + TIME_W'(1);
                            n_state = ST_TICK_SCAN;
                        end
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end

            // insert at the table end or reject when full
            ST_SEND: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_res.id      = r_next_id;
                    out_res.payload = r_pay;
                    out_res.peer    = r_peer;
                    out_res.flags   = r_flg;
                    out_res.last    = 1'b1;
                    if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                        out_res.kind    = KIND_REJECT;
                        out_res.pending = PEND_W'(r_count);
                        out_res.tx      = r_tx;
                    end else begin
                        tbl_we          = 1'b1;
                        tbl_widx        = r_count[TIDX_W-1:0];
                        tbl_wentry      = '{id: r_next_id, payload: r_pay, peer: r_peer,
                                            flags: r_flg, sent: r_now};
                        n_count         = r_count + CNT_W'(1);
                        n_tx            = tx_inc;
                        n_next_id       = (id_inc >= (ID_W + 1)'(ID_COUNT)) ?
                                          '0 : id_inc[ID_W-1:0];
                        out_res.kind    = KIND_SENT;
                        out_res.pending = PEND_W'(r_count + CNT_W'(1));
                        out_res.tx      = tx_inc;
                    end
                    n_state = ST_IDLE;
                end
            end

            // search the oldest entry with the acked id
            ST_ACK_SCAN: begin
                if (!scan_live) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_res.kind    = KIND_ACK_MISS;
                        out_res.id      = r_id;
                        out_res.pending = PEND_W'(r_count);
                        out_res.tx      = r_tx;
                        out_res.last    = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else if (alu_hit) begin
                    if (out_free) begin
                        out_load        = 1'b1;
                        out_res.kind    = KIND_ACK_HIT;
                        out_res.id      = r_id;
                        out_res.payload = rd_entry.payload;
                        out_res.peer    = rd_entry.peer;
                        out_res.flags   = rd_entry.flags;
                        out_res.pending = PEND_W'(r_count - CNT_W'(1));
                        out_res.tx      = r_tx;
                        out_res.last    = 1'b1;
                        n_state         = ST_ACK_SHIFT;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end

            // close the gap one entry per cycle
            ST_ACK_SHIFT: begin
                if (idx_inc < r_count) begin
                    tbl_we = 1'b1;
                    n_idx  = idx_inc;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_IDLE;
                end
            end

            // bitmap read in flight
            ST_DATA_RD: begin
                n_state = ST_DATA_WR;
            end

            // deliver a new id or acknowledge a duplicate
            ST_DATA_WR: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_res.id      = r_id;
                    out_res.peer    = r_peer;
                    out_res.pending = PEND_W'(r_count);
                    out_res.tx      = r_tx;
                    out_res.last    = 1'b1;
                    if (id_in_range && !ram_rdata[0]) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_id[MAP_AW-1:0];
                        ram_wdata    = 1'b1;
                        out_res.kind = KIND_DELIVER;
                    end else begin
                        out_res.kind = KIND_DUP;
                    end
                    n_state = ST_IDLE;
                end
            end

            // retransmit expired entries, one result held back for the last flag
            ST_TICK_SCAN: begin
                if (!scan_live) begin
                    n_state = ST_TICK_END;
                end else if (alu_hit) begin
                    if (!r_hold_v || out_free) begin
                        out_load        = r_hold_v;
                        out_res         = r_hold;
                        tbl_we          = 1'b1;
                        tbl_wentry.sent = r_now;
                        n_tx            = tx_inc;
                        n_hold_v        = 1'b1;
                        n_hold          = '{kind: KIND_RETX, id: rd_entry.id,
                                            payload: rd_entry.payload, peer: rd_entry.peer,
                                            flags: rd_entry.flags,
                                            pending: PEND_W'(r_count), tx: tx_inc,
                                            last: 1'b0};
                        n_idx           = idx_inc;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end

            // hand over the held result as the last one
            ST_TICK_END: begin
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    out_load     = 1'b1;
                    out_res      = r_hold;
                    out_res.last = 1'b1;
                    n_hold_v     = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_idx       <= '0;
            r_count     <= '0;
            r_next_id   <= '0;
            r_now       <= '0;
            r_tx        <= '0;
            r_timeout   <= TO_W'(2);
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_hold_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_count    <= n_count;
            r_next_id  <= n_next_id;
            r_now      <= n_now;
            r_tx       <= n_tx;
            r_clr_addr <= n_clr_addr;
            r_hold_v   <= n_hold_v;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_pay  <= n_pay;
        r_peer <= n_peer;
        r_flg  <= n_flg;
        r_hold <= n_hold;
        if (out_load) begin
            r_out <= out_res;
        end
    end

    // result ports
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_out_id        = r_out.id;
    assign o_out_payload   = r_out.payload;
    assign o_out_peer      = r_out.peer;
    assign o_out_flags     = r_out.flags;
    assign o_pending_now   = r_out.pending;
    assign o_transmissions = r_out.tx;
    assign o_last          = r_out.last;

    // table never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("pending count above table depth");

    // held retransmit only lives inside a tick
    a_hold_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_state == ST_TICK_SCAN || r_state == ST_TICK_END))
        else $error("held result outside tick processing");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + CNT_W'(1) ||
                            r_count == $past(r_count) - CNT_W'(1)))
        else $error("pending count jumped");

    // transmission total never goes back
    a_tx_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_tx >= $past(r_tx))
        else $error("transmission total decreased");

    // no result is produced while the bitmap is being cleared
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> !out_load && !tbl_we)
        else $error("activity during bitmap clear");

endmodule

`default_nettype wire

// ----- hw/rtl/ratu_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module ratu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ratu_table.sv -----
// pending message table: one registered read port and one write port
`default_nettype none

module ratu_table (
    input  wire logic                       i_clk,
    input  wire logic [ratu_pkg::TIDX_W-1:0] i_rd_idx,
    output ratu_pkg::t_entry                 o_rd_entry,
    input  wire logic                       i_wr_en,
    input  wire logic [ratu_pkg::TIDX_W-1:0] i_wr_idx,
    input  ratu_pkg::t_entry                 i_wr_entry
);
    import ratu_pkg::*;

    logic [$bits(t_entry)-1:0] rd_data;

    // entry storage, written for insert, compaction and time refresh
    ratu_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_idx),
        .i_wdata (i_wr_entry),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_data)
    );

    // entry read back from the registered read port
    assign o_rd_entry = t_entry'(rd_data);

endmodule

`default_nettype wire

// ----- hw/rtl/ratu_alu.sv -----
// shared compare unit: id match or timeout age check
`default_nettype none

module ratu_alu (
    input  ratu_pkg::t_alu_req i_req,
    output logic               o_hit
);
    import ratu_pkg::*;

    logic [TIME_W-1:0] age;

    // age is taken modulo 2^32
    assign age = i_req.a - i_req.b;

    always_comb begin
        case (i_req.op)
            ALU_EQ:  o_hit = (i_req.a == i_req.b);
            ALU_AGE: o_hit = (age >= i_req.c);
            default: o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire
